// ===== design/stream_substring_substitute_defines.svh =====
// Assertion helpers for the find-and-replace block.
`ifndef STREAM_SUBSTRING_SUBSTITUTE_DEFINES_SVH
`define STREAM_SUBSTRING_SUBSTITUTE_DEFINES_SVH

`ifndef SYNTHESIS

`define SSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define SSS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

`else

`define SSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define SSS_ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

// ===== design/sss_pkg.sv =====
`default_nettype none

package sss_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int LEN_W       = 4;
    localparam int FILL_W      = 3;
    localparam int WORD_W      = 64;

    typedef enum logic [2:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_BYTES  = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_ONLY_ONE_INSTANCE  = 3'd4,
        REG_INSTANCE_NUMBER    = 3'd5
    } cfg_index_t;

    // One queued run of output beats for the back end.
    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [LEN_W-1:0]  count;
        logic              last;
    } job_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        clamp_len = (len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len;
    endfunction

endpackage

`default_nettype wire

// ===== design/stream_substring_substitute.sv =====
// Channel   Handshake                Payload
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
// in        in_valid / in_ready      text_byte, text_end
// out       out_valid / out_ready    out_byte, byte_present, out_end
//
// The front end takes one text byte per cycle while the two-entry run queue has room.
// The back end sends one beat per cycle while out_ready is high; a byte that causes n result
// beats (up to 8) holds it for those n beats, so sustained input rate follows the beats per byte.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
// Input stalls only when the run queue is full; out_ready stalls only the back end.
`default_nettype none

module stream_substring_substitute
    import sss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        text_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             byte_present,
    output logic             out_end
);

    job_t front_job;
    job_t head_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    assign in_ready = !q_full;

    sss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (in_valid && in_ready),
        .text_byte (text_byte),
        .text_end  (text_end),
        .push      (push),
        .job       (front_job)
    );

    sss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    sss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .q_empty      (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .out_end      (out_end)
    );

endmodule

`default_nettype wire

// ===== design/sss_front.sv =====
`default_nettype none
`include "stream_substring_substitute_defines.svh"

module sss_front
    import sss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        accept,
    input  wire logic [7:0]  text_byte,
    input  wire logic        text_end,
    output logic             push,
    output job_t             job
);

    logic [WORD_W-1:0] pattern_reg;
    logic [LEN_W-1:0]  pattern_len_reg;
    logic [WORD_W-1:0] repl_reg;
    logic [LEN_W-1:0]  repl_len_reg;
    logic              only_one_reg;
    logic [15:0]       instance_reg;

    logic [WORD_W-1:0] window_reg, window_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       hit_count_reg, hit_count_next;

    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  fill_inc;
    logic [WORD_W-1:0] win_ins;
    logic              full;
    logic              hit;
    logic              selected;

    assign cfg_ready = 1'b1;
    assign plen      = clamp_len(pattern_len_reg);
    assign rlen      = clamp_len(repl_len_reg);
    assign fill_inc  = {1'b0, fill_reg} + LEN_W'(1);
    assign full      = (fill_inc == plen);

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_ins[8*i +: 8] = (FILL_W'(i) == fill_reg) ? text_byte : window_reg[8*i +: 8];
        end
    end

    always_comb
    begin
        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((LEN_W'(i) < plen) && (win_ins[8*i +: 8] != pattern_reg[8*i +: 8]))
            begin
                hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        window_next    = window_reg;
        fill_next      = fill_reg;
        hit_count_next = hit_count_reg;
        selected       = 1'b0;
        job.bytes      = win_ins;
        job.count      = '0;
        job.last       = text_end;

        if (plen == '0)
        begin
            job.bytes = {{(WORD_W-8){1'b0}}, text_byte};
            job.count = LEN_W'(1);
        end
        else
        begin
            window_next = win_ins;
            fill_next   = fill_inc[FILL_W-1:0];
            if (full && hit)
            begin
                // Saturated counter never selects.
                if (hit_count_reg != 16'hFFFF)
                begin
                    selected       = ((hit_count_reg + 16'd1) == instance_reg);
                    hit_count_next = hit_count_reg + 16'd1;
                end
                if (!only_one_reg || selected)
                begin
                    job.bytes = repl_reg;
                    job.count = rlen;
                end
                else
                begin
                    job.count = plen;
                end
                fill_next = '0;
            end
            else if (full)
            begin
                job.count   = LEN_W'(1);
                window_next = win_ins >> 8;
                fill_next   = FILL_W'(plen - LEN_W'(1));
            end
            // Flush: miss emits oldest plus the rest, which is the whole window so far.
            if (text_end && !(full && hit))
            begin
                job.count = fill_inc;
            end
        end

        if (text_end)
        begin
            fill_next      = '0;
            hit_count_next = '0;
        end
    end

    assign push = accept && ((job.count != '0) || text_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            pattern_len_reg <= '0;
            repl_reg        <= '0;
            repl_len_reg    <= '0;
            only_one_reg    <= 1'b0;
            instance_reg    <= 16'd1;
            fill_reg        <= '0;
            hit_count_reg   <= '0;
        end
        else
        begin
            // A new pattern length drops whatever is buffered.
            if (cfg_valid && cfg_ready && (cfg_index == REG_PATTERN_LENGTH))
            begin
                fill_reg      <= '0;
                hit_count_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg      <= fill_next;
                hit_count_reg <= hit_count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_PATTERN_BYTES:      pattern_reg <= cfg_data;
                    REG_PATTERN_LENGTH:     pattern_len_reg <= cfg_data[LEN_W-1:0];
                    REG_REPLACEMENT_BYTES:  repl_reg <= cfg_data;
                    REG_REPLACEMENT_LENGTH: repl_len_reg <= cfg_data[LEN_W-1:0];
                    REG_ONLY_ONE_INSTANCE:  only_one_reg <= cfg_data[0];
                    REG_INSTANCE_NUMBER:    instance_reg <= cfg_data[15:0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg <= window_next;
        end
    end

    `SSS_ASSERT_IMPLIES(a_fill_below_len, clk, rst_n, plen != '0, {1'b0, fill_reg} < plen)
    `SSS_ASSERT_IMPLIES(a_end_always_pushes, clk, rst_n, accept && text_end, push)

endmodule

`default_nettype wire

// ===== design/sss_queue.sv =====
`default_nettype none
`include "stream_substring_substitute_defines.svh"

module sss_queue
    import sss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output job_t      head_job,
    output logic      full,
    output logic      empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `SSS_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
    `SSS_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

`default_nettype wire

// ===== design/sss_back.sv =====
`default_nettype none
`include "stream_substring_substitute_defines.svh"

module sss_back
    import sss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  job_t            head_job,
    input  wire logic       q_empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_present,
    output logic            out_end
);

    job_t              job_reg;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic              busy_reg, busy_next;
    logic              job_done;

    assign job_done     = (job_reg.count == '0) || (({1'b0, idx_reg} + LEN_W'(1)) == job_reg.count);
    assign out_valid    = busy_reg;
    assign byte_present = (job_reg.count != '0);
    // The empty end marker carries a zero byte.
    assign out_byte     = byte_present ? job_reg.bytes[8*idx_reg +: 8] : 8'h00;
    assign out_end      = job_reg.last && job_done;

    // Load the next run once the current one has handed over its final beat.
    assign pop = !q_empty && (!busy_reg || (out_ready && job_done));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg && out_ready)
        begin
            if (job_done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
    end

    `SSS_ASSERT_IMPLIES(a_empty_only_at_end, clk, rst_n, out_valid && !byte_present, out_end)

endmodule

`default_nettype wire
